/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the vector-matrix product core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define VMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define VMP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* rtl/core/vmp_pkg.sv */
// ----------------------------------------------------------------------------
// vmp_pkg
// Types, constants and helpers shared by the vector-matrix product core.
// ----------------------------------------------------------------------------
`default_nettype none

package vmp_pkg;

    // Store depths and counter widths
    localparam int unsigned MAX_LENGTH  = 1024;
    localparam int unsigned MAX_COLUMNS = 1024;
    localparam int unsigned ROW_W       = $clog2(MAX_LENGTH);
    localparam int unsigned COL_W       = $clog2(MAX_COLUMNS);

    // Fixed field widths
    localparam int unsigned IDX_W     = 10;
    localparam int unsigned OPND_W    = 32;
    localparam int unsigned ACC_W     = 64;
    localparam int unsigned COLNUM_W  = 10;
    localparam int unsigned CFG_W     = 11;
    localparam int unsigned CFG_IDX_W = 2;

    // Item opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT  = 2'd1;

    // Saturation limits
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Sample item handed from the sequencer to the MAC stage
    typedef struct packed {
        logic                     row0;   // first row: start the column fresh
        logic                     emit;   // last row: deliver the column sum
        logic                     last;   // last column of the matrix
        logic [COL_W-1:0]         col;
        logic signed [OPND_W-1:0] operand;
    } t_s1;

    // Clamp a count register to [1, lim] and return it minus one
    function automatic logic [CFG_W-1:0] limit_m1(input logic [CFG_W-1:0] v,
                                                  input int unsigned lim);
        logic [CFG_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (32'(v) > lim) begin
            res = CFG_W'(lim - 1);
        end else begin
            res = v - CFG_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/vmp_seq.sv */
// ----------------------------------------------------------------------------
// vmp_seq
// Input stage: configuration, row/column counters, weight store and the
// registered weight read for each sample.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vmp_seq
    import vmp_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_W-1:0]         i_cfg_data,
    input  wire logic                     i_in_valid,
    input  wire logic                     i_advance,
    input  wire logic                     i_op,
    input  wire logic [IDX_W-1:0]         i_weight_index,
    input  wire logic signed [OPND_W-1:0] i_operand_value,
    output logic                          o_s1_valid,
    output t_s1                           o_s1,
    output logic signed [OPND_W-1:0]      o_s1_weight
);

    logic signed [OPND_W-1:0] weight_mem [MAX_LENGTH];

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_len_m1, n_len_m1;
    logic [COL_W-1:0] r_cols_m1, n_cols_m1;
    logic             r_s1_valid;
    t_s1              r_s1;
    logic signed [OPND_W-1:0] r_s1_weight;

    logic w_accept;
    logic w_sample;
    logic w_load;
    logic w_in_range;
    logic w_wrap;
    logic w_at_start;

    assign w_accept = i_in_valid && i_advance;
    assign w_sample = w_accept && (i_op == OP_SAMPLE);
    assign w_load   = w_accept && (i_op == OP_LOAD);

    // Next counters and limits: a count register write restarts the matrix
    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_len_m1  = r_len_m1;
        n_cols_m1 = r_cols_m1;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VECTOR_LENGTH: begin
                    n_len_m1 = ROW_W'(limit_m1(i_cfg_data, MAX_LENGTH));
                    n_row    = '0;
                    n_col    = '0;
                end
                CFG_COLUMN_COUNT: begin
                    n_cols_m1 = COL_W'(limit_m1(i_cfg_data, MAX_COLUMNS));
                    n_row     = '0;
                    n_col     = '0;
                end
                default: begin
                end
            endcase
        end else if (w_sample) begin
            if (r_col == r_cols_m1) begin
                n_col = '0;
                n_row = (r_row == r_len_m1) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_len_m1   <= '0;
            r_cols_m1  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_row     <= n_row;
            r_col     <= n_col;
            r_len_m1  <= n_len_m1;
            r_cols_m1 <= n_cols_m1;
            if (i_advance) begin
                r_s1_valid <= w_sample;
            end
        end
    end

    // Weight store: write on a load transfer, read the current row per sample
    always_ff @(posedge i_clk) begin
        if (w_load && (32'(i_weight_index) < MAX_LENGTH)) begin
            weight_mem[i_weight_index[ROW_W-1:0]] <= i_operand_value;
        end
        if (i_advance) begin
            r_s1_weight <= weight_mem[r_row];
        end
    end

    // Capture the sample and its position flags
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s1.row0    <= (r_row == '0);
            r_s1.emit    <= (r_row == r_len_m1);
            r_s1.last    <= (r_col == r_cols_m1);
            r_s1.col     <= r_col;
            r_s1.operand <= i_operand_value;
        end
    end

    assign o_s1_valid  = r_s1_valid;
    assign o_s1        = r_s1;
    assign o_s1_weight = r_s1_weight;

    // Counter checks
    assign w_in_range = (r_row <= r_len_m1) && (r_col <= r_cols_m1);
    assign w_wrap     = w_sample && !i_cfg_we && (r_row == r_len_m1) && (r_col == r_cols_m1);
    assign w_at_start = (r_row == '0) && (r_col == '0);

    `VMP_ASSERT(a_counters_in_range, w_in_range, "counter beyond limit")
    `VMP_ASSERT(a_matrix_wrap, w_wrap |=> w_at_start, "counters did not wrap at matrix end")

endmodule

`default_nettype wire

/* rtl/core/vmp_mac.sv */
// ----------------------------------------------------------------------------
// vmp_mac
// Multiply, column accumulator store with forwarding, saturating add and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vmp_mac
    import vmp_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s1_valid,
    input  wire t_s1                      i_s1,
    input  wire logic signed [OPND_W-1:0] i_s1_weight,
    input  wire logic                     i_out_stall,
    output logic                          o_advance,
    output logic                          o_out_valid,
    output logic signed [ACC_W-1:0]       o_column_sum,
    output logic [COLNUM_W-1:0]           o_column_number,
    output logic                          o_saturated,
    output logic                          o_last_of_matrix
);

    // Accumulator store: saturation mark above the 64-bit sum
    logic [ACC_W:0] acc_mem [MAX_COLUMNS];

    logic                     r_s2_valid;
    logic                     r_s2_row0;
    logic                     r_s2_emit;
    logic                     r_s2_last;
    logic [COL_W-1:0]         r_s2_col;
    logic signed [ACC_W-1:0]  r_s2_prod;
    logic [ACC_W:0]           r_s2_rd;
    logic                     r_fwd_valid;
    logic [COL_W-1:0]         r_fwd_col;
    logic [ACC_W:0]           r_fwd_data;
    logic                     r_out_valid;
    logic signed [ACC_W-1:0]  r_out_sum;
    logic [COLNUM_W-1:0]      r_out_col;
    logic                     r_out_sat;
    logic                     r_out_last;

    logic                     w_advance;
    logic signed [ACC_W-1:0]  w_prod;
    logic [ACC_W:0]           w_acc_in;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [ACC_W-1:0]  w_sum;
    logic                     w_ovf;
    logic signed [ACC_W-1:0]  w_new_sum;
    logic                     w_new_sat;

    // Move the whole pipe unless a held result is stalled
    assign w_advance = !r_out_valid || !i_out_stall;
    assign w_prod    = i_s1.operand * i_s1_weight;

    // Take the sum written last cycle when the read raced that write
    assign w_acc_in = (r_fwd_valid && (r_fwd_col == r_s2_col)) ? r_fwd_data : r_s2_rd;
    assign w_acc    = w_acc_in[ACC_W-1:0];
    assign w_sum    = w_acc + r_s2_prod;
    assign w_ovf    = (w_acc[ACC_W-1] == r_s2_prod[ACC_W-1]) &&
                      (w_sum[ACC_W-1] != w_acc[ACC_W-1]);

    // Start fresh on the first row, else add and clip
    always_comb begin
        if (r_s2_row0) begin
            w_new_sum = r_s2_prod;
            w_new_sat = 1'b0;
        end else if (w_ovf) begin
            w_new_sum = w_acc[ACC_W-1] ? ACC_MIN : ACC_MAX;
            w_new_sat = 1'b1;
        end else begin
            w_new_sum = w_sum;
            w_new_sat = w_acc_in[ACC_W];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_s2_valid  <= i_s1_valid;
            r_fwd_valid <= r_s2_valid;
            r_out_valid <= r_s2_valid && r_s2_emit;
        end
    end

    // Product register and accumulator read
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s2_row0 <= i_s1.row0;
            r_s2_emit <= i_s1.emit;
            r_s2_last <= i_s1.last;
            r_s2_col  <= i_s1.col;
            r_s2_prod <= w_prod;
            r_s2_rd   <= acc_mem[i_s1.col];
        end
    end

    // Write back the column and keep a copy for forwarding
    always_ff @(posedge i_clk) begin
        if (w_advance && r_s2_valid) begin
            acc_mem[r_s2_col] <= {w_new_sat, w_new_sum};
        end
        if (w_advance) begin
            r_fwd_col  <= r_s2_col;
            r_fwd_data <= {w_new_sat, w_new_sum};
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_advance && r_s2_valid && r_s2_emit) begin
            r_out_sum  <= w_new_sum;
            r_out_col  <= COLNUM_W'(r_s2_col);
            r_out_sat  <= w_new_sat;
            r_out_last <= r_s2_last;
        end
    end

    assign o_advance        = w_advance;
    assign o_out_valid      = r_out_valid;
    assign o_column_sum     = r_out_sum;
    assign o_column_number  = r_out_col;
    assign o_saturated      = r_out_sat;
    assign o_last_of_matrix = r_out_last;

    `VMP_ASSERT(a_emit_delivered, (w_advance && r_s2_valid && r_s2_emit) |=> r_out_valid, "finished column sum lost")
    `VMP_ASSERT(a_first_row_clean, (w_advance && r_s2_valid && r_s2_emit && r_s2_row0) |=> !r_out_sat, "single-row sum marked saturated")

endmodule

`default_nettype wire

/* rtl/core/vector_matrix_product.sv */
// ----------------------------------------------------------------------------
// vector_matrix_product
// Path: a last-row sample passes the input, product and result registers.
// Throughput: one item per cycle, loads and samples alike; the pipe only
// holds while a delivered result is stalled at the output register.
// Reset: synchronous, clears counters, sets both counts to 1; no memory sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_matrix_product
    import vmp_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_W-1:0]         i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_op,
    input  wire logic [IDX_W-1:0]         i_weight_index,
    input  wire logic signed [OPND_W-1:0] i_operand_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [ACC_W-1:0]       o_column_sum,
    output logic [COLNUM_W-1:0]           o_column_number,
    output logic                          o_saturated,
    output logic                          o_last_of_matrix
);

    logic                     w_advance;
    logic                     w_s1_valid;
    t_s1                      w_s1;
    logic signed [OPND_W-1:0] w_s1_weight;

    // Stall input while the result register is held
    assign o_in_stall = !w_advance;

    // Counters, configuration and weight store
    vmp_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_advance       (w_advance),
        .i_op            (i_op),
        .i_weight_index  (i_weight_index),
        .i_operand_value (i_operand_value),
        .o_s1_valid      (w_s1_valid),
        .o_s1            (w_s1),
        .o_s1_weight     (w_s1_weight)
    );

    // Multiply-accumulate and result register
    vmp_mac u_mac (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s1_valid       (w_s1_valid),
        .i_s1             (w_s1),
        .i_s1_weight      (w_s1_weight),
        .i_out_stall      (i_out_stall),
        .o_advance        (w_advance),
        .o_out_valid      (o_out_valid),
        .o_column_sum     (o_column_sum),
        .o_column_number  (o_column_number),
        .o_saturated      (o_saturated),
        .o_last_of_matrix (o_last_of_matrix)
    );

endmodule

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vector_matrix_product: streams weight loads and
// matrix elements through the input channel under random idle and stall,
// predicts each column sum in a scoreboard and compares every output transfer.
// ----------------------------------------------------------------------------

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vmp_pkg::*;

    // Spare register indexes: writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int IDLE_PCT     = 22;
    localparam int SETTLE_CYC   = 8;
    localparam int SQUEEZE_CYC  = 200;
    localparam int RANDOM_ITEMS = 550;

    // One expected column sum
    typedef struct {
        logic signed [ACC_W-1:0] sum;
        logic [COLNUM_W-1:0]     column;
        logic                    sat;
        logic                    last;
    } column_result_t;

    // Scoreboard: tracks weights, column accumulators and counters
    class product_checker;
        logic signed [OPND_W-1:0] weights [MAX_LENGTH];
        logic signed [ACC_W-1:0]  col_acc [MAX_COLUMNS];
        logic                     col_sat [MAX_COLUMNS];
        int unsigned              row_idx;
        int unsigned              col_idx;
        logic [CFG_W-1:0]         len_reg;
        logic [CFG_W-1:0]         cols_reg;
        column_result_t           pending_sums [$];
        int                       errors;

        function new();
            row_idx  = 0;
            col_idx  = 0;
            len_reg  = 1;
            cols_reg = 1;
            errors   = 0;
            foreach (col_acc[i]) begin
                col_acc[i] = '0;
                col_sat[i] = 1'b0;
            end
        endfunction

        // Zero acts as one, anything above the store size as the maximum
        function int unsigned eff_count(logic [CFG_W-1:0] v, int unsigned lim);
            if (v == '0) return 1;
            if (32'(v) > lim) return lim;
            return 32'(v);
        endfunction

        function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_VECTOR_LENGTH) begin
                len_reg = data;
            end else if (idx == CFG_COLUMN_COUNT) begin
                cols_reg = data;
            end else begin
                return;
            end
            row_idx = 0;
            col_idx = 0;
        endfunction

        // Note an accepted input transfer and queue the sum it completes
        function void note_item(logic op, logic [IDX_W-1:0] idx,
                                logic signed [OPND_W-1:0] val);
            logic signed [ACC_W-1:0] prod;
            logic signed [ACC_W-1:0] acc;
            logic signed [ACC_W-1:0] sum;
            int unsigned             rows;
            int unsigned             cols;
            column_result_t          res;
            if (op == OP_LOAD) begin
                weights[idx] = val;
                return;
            end
            rows = eff_count(len_reg, MAX_LENGTH);
            cols = eff_count(cols_reg, MAX_COLUMNS);
            prod = longint'(weights[row_idx]) * longint'(val);
            if (row_idx == 0) begin
                // first row starts the column fresh
                col_acc[col_idx] = prod;
                col_sat[col_idx] = 1'b0;
            end else begin
                acc = col_acc[col_idx];
                sum = acc + prod;
                if (acc[ACC_W-1] == prod[ACC_W-1] && sum[ACC_W-1] != acc[ACC_W-1]) begin
                    sum = acc[ACC_W-1] ? ACC_MIN : ACC_MAX;
                    col_sat[col_idx] = 1'b1;
                end
                col_acc[col_idx] = sum;
            end
            if (row_idx == rows - 1) begin
                res.sum    = col_acc[col_idx];
                res.column = COLNUM_W'(col_idx);
                res.sat    = col_sat[col_idx];
                res.last   = (col_idx == cols - 1);
                pending_sums.push_back(res);
            end
            // advance column, then row, wrapping into the next matrix
            col_idx++;
            if (col_idx >= cols) begin
                col_idx = 0;
                row_idx++;
                if (row_idx >= rows) row_idx = 0;
            end
        endfunction

        // Compare an output transfer with the oldest expected sum
        function void check_sum(logic signed [ACC_W-1:0] sum, logic [COLNUM_W-1:0] col,
                                logic sat, logic last);
            column_result_t want;
            if (pending_sums.size() == 0) begin
                $error("column sum %0d for column %0d arrived with none pending", sum, col);
                errors++;
                return;
            end
            want = pending_sums.pop_front();
            if (sum !== want.sum) begin
                $error("column_sum: expected %0d, actual %0d", want.sum, sum);
                errors++;
            end
            if (col !== want.column) begin
                $error("column_number: expected %0d, actual %0d", want.column, col);
                errors++;
            end
            if (sat !== want.sat) begin
                $error("saturated: expected %0d, actual %0d", want.sat, sat);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_matrix: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_W-1:0]         i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_op = OP_LOAD;
    logic [IDX_W-1:0]         i_weight_index = '0;
    logic signed [OPND_W-1:0] i_operand_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [ACC_W-1:0]  o_column_sum;
    logic [COLNUM_W-1:0]      o_column_number;
    logic                     o_saturated;
    logic                     o_last_of_matrix;

    product_checker pred = new();
    bit             calm = 1'b0;
    bit             squeeze_req = 1'b0;

    vector_matrix_product dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_weight_index   (i_weight_index),
        .i_operand_value  (i_operand_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_column_sum     (o_column_sum),
        .o_column_number  (o_column_number),
        .o_saturated      (o_saturated),
        .o_last_of_matrix (o_last_of_matrix)
    );

    always #2 i_clk = ~i_clk;

    // Hard stop on a hung run
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Extremes often, plain random otherwise
    function automatic logic signed [OPND_W-1:0] pick_operand(bit heavy);
        int unsigned pct;
        pct = heavy ? 70 : 25;
        if ($urandom_range(99) < pct) begin
            case ($urandom_range(4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0001_0000;
            endcase
        end
        return $urandom;
    endfunction

    // Write one register; entered and left at a rising edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        pred.apply_config(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one item, with random idle first; return at its transfer edge
    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic signed [OPND_W-1:0] val);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_weight_index  <= idx;
        i_operand_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        pred.note_item(op, idx, val);
    endtask

    // Drop valid, drain every expected sum, then let the pipe settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pred.pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // One phase: optional new shape, load every row weight, then mixed items
    task automatic run_phase(input logic [CFG_W-1:0] len_v, input logic [CFG_W-1:0] cols_v,
                             input int n, input bit heavy, input bit reconfig,
                             input int load_pct);
        int unsigned rows;
        wait_idle();
        if (reconfig) begin
            write_reg(CFG_VECTOR_LENGTH, len_v);
            write_reg(CFG_COLUMN_COUNT, cols_v);
        end
        rows = pred.eff_count(pred.len_reg, MAX_LENGTH);
        for (int i = 0; i < int'(rows); i++)
            send_item(OP_LOAD, IDX_W'(i), pick_operand(heavy));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < load_pct)
                send_item(OP_LOAD, IDX_W'($urandom_range(1023)), pick_operand(heavy));
            else
                send_item(OP_SAMPLE, IDX_W'($urandom), pick_operand(heavy));
        end
    endtask

    // Receiver: check each output transfer, stall at random or hold off
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                pred.check_sum(o_column_sum, o_column_number, o_saturated, o_last_of_matrix);
            if (squeeze_req) begin
                hold = SQUEEZE_CYC;
                squeeze_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Stimulus
    initial begin
        int random_items;
        int n;
        bit heavy;
        random_items = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x2 matrices: positive and negative clipping, then a fresh first row
        write_reg(CFG_VECTOR_LENGTH, 11'd3);
        write_reg(CFG_COLUMN_COUNT, 11'd2);
        send_item(OP_LOAD, 10'd0, 32'h8000_0000);
        send_item(OP_LOAD, 10'd1, 32'h8000_0000);
        send_item(OP_LOAD, 10'd2, 32'h8000_0000);
        send_item(OP_LOAD, 10'd1023, 32'h7FFF_FFFF);
        for (int r = 0; r < 3; r++) begin
            send_item(OP_SAMPLE, 10'd0, 32'h8000_0000);
            send_item(OP_SAMPLE, 10'd1023, 32'h7FFF_FFFF);
        end
        // loads in mid-matrix change the weight of the rows that follow
        send_item(OP_SAMPLE, 10'd0, 32'h7FFF_FFFF);
        send_item(OP_SAMPLE, 10'd0, 32'h0000_0000);
        send_item(OP_LOAD, 10'd1, 32'h7FFF_FFFF);
        send_item(OP_SAMPLE, 10'd0, 32'h7FFF_FFFF);
        send_item(OP_SAMPLE, 10'd0, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 10'd2, 32'h0000_0000);
        send_item(OP_SAMPLE, 10'd0, 32'h8000_0000);
        send_item(OP_SAMPLE, 10'd0, 32'h0001_0000);
        // leave a matrix half done; the next register write restarts it
        send_item(OP_SAMPLE, 10'd0, 32'h0001_0000);

        // widest row: column register above range acts as 1024 columns, no idling
        calm = 1'b1;
        run_phase(11'd0, 11'h7FF, 1024, 1'b0, 1'b1, 0);
        calm = 1'b0;

        // spare indexes are ignored
        wait_idle();
        write_reg(CFG_SPARE_LO, 11'h7FF);
        write_reg(CFG_SPARE_HI, 11'h000);

        // hold off the receiver while the sender keeps offering
        wait_idle();
        write_reg(CFG_VECTOR_LENGTH, 11'd1);
        write_reg(CFG_COLUMN_COUNT, 11'd3);
        send_item(OP_LOAD, 10'd0, pick_operand(1'b0));
        squeeze_req = 1'b1;
        calm = 1'b1;
        run_phase(11'd1, 11'd3, 150, 1'b0, 1'b0, 0);
        calm = 1'b0;

        // random shapes, sometimes continuing across a spare write
        while (random_items < RANDOM_ITEMS) begin
            n = $urandom_range(150, 40);
            heavy = ($urandom_range(2) == 0);
            if ($urandom_range(3) == 0) begin
                wait_idle();
                write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_W'($urandom));
                run_phase('0, '0, n, heavy, 1'b0, 15);
            end else begin
                run_phase(CFG_W'($urandom_range(6)), CFG_W'($urandom_range(6)), n, heavy,
                          1'b1, 15);
            end
            random_items += n;
        end

        wait_idle();
        if (pred.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
